// File: hdl/rsse_pkg.sv
// Shared types and constants for the session sequence engine.
`default_nettype none
package rsse_pkg;
    localparam logic [3:0] OP_DATA     = 4'd0;
    localparam logic [3:0] OP_FRAG     = 4'd1;
    localparam logic [3:0] OP_ACK      = 4'd2;
    localparam logic [3:0] OP_OOACK    = 4'd3;
    localparam logic [3:0] OP_REQ      = 4'd4;
    localparam logic [3:0] OP_RESP     = 4'd5;
    localparam logic [3:0] OP_DISC     = 4'd6;
    localparam logic [3:0] OP_ASSIGN   = 4'd7;
    localparam logic [3:0] OP_POLL     = 4'd8;
    localparam logic [3:0] OP_NONE     = 4'd15;

    localparam logic [3:0] ACT_IGNORED    = 4'd0;
    localparam logic [3:0] ACT_DELIVER    = 4'd1;
    localparam logic [3:0] ACT_DELIVER_C  = 4'd2;
    localparam logic [3:0] ACT_OOACK      = 4'd3;
    localparam logic [3:0] ACT_DUP        = 4'd4;
    localparam logic [3:0] ACT_FRAG_STORE = 4'd5;
    localparam logic [3:0] ACT_FRAG_DONE  = 4'd6;
    localparam logic [3:0] ACT_FRAG_DONEC = 4'd7;
    localparam logic [3:0] ACT_RELEASE    = 4'd8;
    localparam logic [3:0] ACT_RESPONSE   = 4'd9;
    localparam logic [3:0] ACT_DISCONNECT = 4'd10;
    localparam logic [3:0] ACT_SEND_ACK   = 4'd11;
    localparam logic [3:0] ACT_ASSIGNED   = 4'd12;
    localparam logic [3:0] ACT_OVERRUN    = 4'd13;
    localparam logic [3:0] ACT_CLOSED     = 4'd14;

    localparam logic [1:0] LINK_CLOSED      = 2'd0;
    localparam logic [1:0] LINK_ESTABLISHED = 2'd1;
    localparam logic [1:0] LINK_CLOSING     = 2'd2;

    localparam logic [31:0] FIXED_KEY      = 32'h1122_3344;
    localparam logic [15:0] DEFAULT_WINDOW = 16'd2048;
    localparam int CMD_W = 4 + 16 + 16 + 32 + 1 + 32 + 32 + 2;
    localparam int RES_W = 4 + 16 + 32 + 32 + 32 + 2 + 1 + 1;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [15:0] seq;
        logic [15:0] payload_length;
        logic [31:0] total_length;
        logic        combined;
        logic [31:0] session_in;
        logic [31:0] key_in;
        logic [1:0]  format_flags;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [15:0] out_seq;
        logic [31:0] session_out;
        logic [31:0] key_out;
        logic [31:0] reassembled_length;
        logic [1:0]  link_state;
        logic        compressed_flag;
        logic        encoded_flag;
    } res_t;

    // 0 current, 1 future, 2 past
    function automatic logic [1:0] seq_class(input logic [15:0] ref_seq,
                                             input logic [15:0] s,
                                             input logic [15:0] win);
        logic [16:0] hi;
        logic        fut;
        hi  = {1'b0, ref_seq} + {1'b0, win};
        fut = ((s > ref_seq) && ({1'b0, s} < hi)) ||
              ((ref_seq >= win) && (s < (ref_seq - win)));
        if (s == ref_seq)
            seq_class = 2'd0;
        else if (fut)
            seq_class = 2'd1;
        else
            seq_class = 2'd2;
    endfunction
endpackage
`default_nettype wire

// File: hdl/rsse_fifo.sv
// Small register queue between the front and back parts, and for results.
`default_nettype none
module rsse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + CW'(do_wr) - CW'(do_rd);
        end
    end
endmodule
`default_nettype wire

// File: hdl/rsse_front.sv
// Front part: takes the transaction and folds unknown opcodes to no-op.
`default_nettype none
module rsse_front
    import rsse_pkg::*;
(
    input  wire logic        in_valid,
    input  wire cmd_t        in_cmd,
    input  wire logic        q_full,
    output logic             q_wr,
    output cmd_t             q_cmd
);
    assign q_wr = in_valid && !q_full;

    always_comb
    begin
        q_cmd = in_cmd;
        if (in_cmd.opcode > OP_POLL)
            q_cmd.opcode = OP_NONE;
    end
endmodule
`default_nettype wire

// File: hdl/rsse_back.sv
// Back part: session state, sequence classing, fragment reassembly.
`default_nettype none
module rsse_back
    import rsse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        q_empty,
    input  wire cmd_t        q_cmd,
    output logic             q_rd,
    input  wire logic        r_full,
    output logic             r_wr,
    output res_t             r_res
);
    logic [15:0] win_reg;
    logic [1:0]  conn_reg, conn_next;
    logic [31:0] sid_reg, sid_next, key_reg, key_next;
    logic [15:0] exp_reg, exp_next, nos_reg, nos_next;
    logic [16:0] ats_reg, ats_next, las_reg, las_next;
    logic [16:0] mas_reg, mas_next, lss_reg, lss_next;
    logic        fa_reg, fa_next;
    logic [31:0] ft_reg, ft_next, fo_reg, fo_next;
    logic [1:0]  mf_reg, mf_next;
    logic [32:0] sum;
    logic [1:0]  c;
    logic        do_op;
    logic        sess_zero;
    logic [3:0]  op_eff;

    assign sess_zero = (sid_reg == '0);
    assign do_op     = !q_empty && !r_full;
    assign q_rd      = do_op;
    assign r_wr      = do_op;
    assign sum       = {1'b0, fo_reg} + {17'd0, q_cmd.payload_length};
    assign c         = seq_class(exp_reg, q_cmd.seq, win_reg);
    // session-bound opcodes are dropped while no session id is set
    assign op_eff    = (((q_cmd.opcode <= OP_OOACK) || (q_cmd.opcode == OP_DISC)) &&
                        sess_zero) ? OP_NONE : q_cmd.opcode;

    always_comb
    begin
        conn_next = conn_reg; sid_next = sid_reg; key_next = key_reg;
        exp_next = exp_reg; nos_next = nos_reg; ats_next = ats_reg;
        las_next = las_reg; mas_next = mas_reg; lss_next = lss_reg;
        fa_next = fa_reg; ft_next = ft_reg; fo_next = fo_reg; mf_next = mf_reg;
        r_res = '0;
        case (op_eff)
            OP_DATA, OP_FRAG:
            begin
                if (c == 2'd1)
                begin
                    r_res.action  = ACT_OOACK;
                    r_res.out_seq = q_cmd.seq;
                end
                else if (c == 2'd2)
                    r_res.action = ACT_DUP;
                else
                begin
                    ats_next = {1'b0, q_cmd.seq};
                    exp_next = exp_reg + 1'b1;
                    if (op_eff == OP_DATA)
                        r_res.action = q_cmd.combined ? ACT_DELIVER_C : ACT_DELIVER;
                    else if (fa_reg)
                    begin
                        if (sum > {1'b0, ft_reg})
                        begin
                            r_res.action = ACT_OVERRUN;
                            fa_next = 1'b0; fo_next = '0;
                        end
                        else if (sum == {1'b0, ft_reg})
                        begin
                            r_res.action = q_cmd.combined ? ACT_FRAG_DONEC : ACT_FRAG_DONE;
                            r_res.reassembled_length = ft_reg;
                            fa_next = 1'b0; fo_next = '0;
                        end
                        else
                        begin
                            r_res.action = ACT_FRAG_STORE;
                            fo_next = sum[31:0];
                        end
                    end
                    else
                    begin
                        ft_next = q_cmd.total_length;
                        if ({16'd0, q_cmd.payload_length} > q_cmd.total_length)
                        begin
                            r_res.action = ACT_OVERRUN;
                            fo_next = '0;
                        end
                        else
                        begin
                            r_res.action = ACT_FRAG_STORE;
                            fa_next = 1'b1;
                            fo_next = {16'd0, q_cmd.payload_length};
                        end
                    end
                end
            end
            OP_ACK:
            begin
                mas_next = {1'b0, q_cmd.seq};
                if ($signed({1'b0, q_cmd.seq}) > $signed(lss_reg))
                    lss_next = {1'b0, q_cmd.seq};
                r_res.action  = ACT_RELEASE;
                r_res.out_seq = q_cmd.seq;
            end
            OP_OOACK:
            begin
                if ((seq_class(mas_reg[15:0], q_cmd.seq, win_reg) == 2'd1) &&
                    (seq_class(nos_reg, q_cmd.seq, win_reg) == 2'd2))
                    lss_next = mas_reg;
            end
            OP_REQ, OP_RESP:
            begin
                if ((op_eff == OP_REQ) && (conn_reg == LINK_ESTABLISHED))
                begin
                    conn_next = LINK_CLOSING;
                    r_res.action = ACT_DISCONNECT;
                end
                else
                begin
                    exp_next = '0; nos_next = '0;
                    ats_next = '1; las_next = '1; mas_next = '1; lss_next = '1;
                    fa_next = 1'b0; ft_next = '0; fo_next = '0;
                    sid_next = q_cmd.session_in;
                    conn_next = LINK_ESTABLISHED;
                    if (op_eff == OP_REQ)
                    begin
                        key_next = FIXED_KEY;
                        r_res.action = ACT_RESPONSE;
                    end
                    else
                    begin
                        key_next = q_cmd.key_in;
                        mf_next = q_cmd.format_flags;
                    end
                end
            end
            OP_DISC:
            begin
                conn_next = LINK_CLOSED;
                r_res.action = ACT_CLOSED;
            end
            OP_ASSIGN:
            begin
                r_res.out_seq = nos_reg;
                nos_next = nos_reg + 1'b1;
                r_res.action = ACT_ASSIGNED;
            end
            OP_POLL:
            begin
                if ($signed(ats_reg) > $signed(las_reg))
                begin
                    las_next = ats_reg;
                    r_res.action = ACT_SEND_ACK;
                    r_res.out_seq = ats_reg[15:0];
                end
            end
            default: ;
        endcase
        r_res.session_out     = sid_next;
        r_res.key_out         = key_next;
        r_res.link_state      = conn_next;
        r_res.compressed_flag = mf_next[0];
        r_res.encoded_flag    = mf_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= DEFAULT_WINDOW;
            conn_reg <= LINK_CLOSED; sid_reg <= '0; key_reg <= '0;
            exp_reg <= '0; nos_reg <= '0;
            ats_reg <= '1; las_reg <= '1; mas_reg <= '1; lss_reg <= '1;
            fa_reg <= 1'b0; ft_reg <= '0; fo_reg <= '0; mf_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                win_reg <= cfg_wdata;
            if (do_op)
            begin
                conn_reg <= conn_next; sid_reg <= sid_next; key_reg <= key_next;
                exp_reg <= exp_next; nos_reg <= nos_next;
                ats_reg <= ats_next; las_reg <= las_next;
                mas_reg <= mas_next; lss_reg <= lss_next;
                fa_reg <= fa_next; ft_reg <= ft_next; fo_reg <= fo_next;
                mf_reg <= mf_next;
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/reliable_session_sequence_engine_top.sv
// Top level of the session sequence engine.
// Path: push enters the command queue; the back part writes its result
// to the result queue. Throughput: one transaction per cycle while pop
// keeps up; the queues let the front and back parts stall on their own.
// Reset: rst_n asynchronous; state clears, window returns to 2048.
`default_nettype none
module reliable_session_sequence_engine_top
    import rsse_pkg::*;
#(
    parameter int QDEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [3:0]  opcode,
    input  wire logic [15:0] seq,
    input  wire logic [15:0] payload_length,
    input  wire logic [31:0] total_length,
    input  wire logic        payload_is_combined,
    input  wire logic [31:0] session_in,
    input  wire logic [31:0] key_in,
    input  wire logic [1:0]  format_flags,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       action,
    output logic [15:0]      out_seq,
    output logic [31:0]      session_out,
    output logic [31:0]      key_out,
    output logic [31:0]      reassembled_length,
    output logic [1:0]       link_state,
    output logic             compressed_flag,
    output logic             encoded_flag
);
    cmd_t in_cmd, q_in, q_out;
    res_t r_in, r_out;
    logic q_full, q_empty, q_wr, q_rd, r_full, r_wr;

    assign in_cmd = '{opcode, seq, payload_length, total_length,
                      payload_is_combined, session_in, key_in, format_flags};
    assign full = q_full;

    rsse_front u_front (
        .in_valid(push), .in_cmd, .q_full, .q_wr, .q_cmd(q_in)
    );

    rsse_fifo #(.WIDTH(CMD_W), .DEPTH(QDEPTH)) u_cq (
        .clk, .rst_n, .wr_en(q_wr), .wr_data(q_in), .full(q_full),
        .rd_en(q_rd), .rd_data(q_out), .empty(q_empty)
    );

    rsse_back u_back (
        .clk, .rst_n, .cfg_we, .cfg_wdata, .q_empty, .q_cmd(q_out), .q_rd,
        .r_full, .r_wr, .r_res(r_in)
    );

    rsse_fifo #(.WIDTH(RES_W), .DEPTH(QDEPTH)) u_rq (
        .clk, .rst_n, .wr_en(r_wr), .wr_data(r_in), .full(r_full),
        .rd_en(pop), .rd_data(r_out), .empty
    );

    assign action             = r_out.action;
    assign out_seq            = r_out.out_seq;
    assign session_out        = r_out.session_out;
    assign key_out            = r_out.key_out;
    assign reassembled_length = r_out.reassembled_length;
    assign link_state         = r_out.link_state;
    assign compressed_flag    = r_out.compressed_flag;
    assign encoded_flag       = r_out.encoded_flag;

    a_front_ops: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> (q_in.opcode <= OP_POLL || q_in.opcode == OP_NONE))
        else $error("unknown opcode passed the front");
    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        (r_wr && r_in.action != ACT_FRAG_DONE && r_in.action != ACT_FRAG_DONEC)
        |-> (r_in.reassembled_length == '0))
        else $error("length on non-completion result");
    a_no_session: assert property (@(posedge clk) disable iff (!rst_n)
        (r_wr && r_in.session_out == '0) |-> (r_in.action == ACT_IGNORED ||
         r_in.action == ACT_RESPONSE || r_in.action == ACT_ASSIGNED ||
         r_in.action == ACT_SEND_ACK || r_in.action == ACT_DISCONNECT))
        else $error("session action without session");
endmodule
`default_nettype wire
